// ----- hdl/lcfb_pkg.sv -----
// ----------------------------------------------------------------------------
// lcfb_pkg
// Shared types, codes and constants of the lidar column frame batcher.
// ----------------------------------------------------------------------------
`default_nettype none

package lcfb_pkg;

   localparam int MAX_COLUMNS_DEFAULT = 4096;

   localparam int INDEX_WIDTH = 13;
   localparam int FRAME_WIDTH = 16;
   localparam int MID_WIDTH   = 16;
   localparam int LOG2_WIDTH  = 3;

   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 13;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COLUMNS_PER_FRAME       = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COLUMNS_PER_PACKET_LOG2 = 1'd1;

   localparam logic [INDEX_WIDTH-1:0] COLUMNS_PER_FRAME_RESET = 13'd1024;
   localparam logic [LOG2_WIDTH-1:0]  LOG2_RESET              = 3'd4;
   localparam logic [LOG2_WIDTH-1:0]  LOG2_MAX                = 3'd6;
   localparam logic [LOG2_WIDTH-1:0]  LOG2_ILLEGAL            = 3'd7;

   localparam logic [2:0] KIND_COLUMN_WRITE  = 3'd0;
   localparam logic [2:0] KIND_ZERO_COLUMNS  = 3'd1;
   localparam logic [2:0] KIND_PACKET_TIME   = 3'd2;
   localparam logic [2:0] KIND_ZERO_SLOTS    = 3'd3;
   localparam logic [2:0] KIND_FRAME_DONE    = 3'd4;
   localparam logic [2:0] KIND_DROPPED       = 3'd5;
   localparam logic [2:0] KIND_FRAME_START   = 3'd6;

   localparam int NUM_STEPS         = 9;
   localparam int STEP_DROP         = 0;
   localparam int STEP_TAIL_COLUMNS = 1;
   localparam int STEP_TAIL_SLOTS   = 2;
   localparam int STEP_COMPLETE     = 3;
   localparam int STEP_START        = 4;
   localparam int STEP_ZERO_SLOTS   = 5;
   localparam int STEP_SLOT_WRITE   = 6;
   localparam int STEP_ZERO_COLUMNS = 7;
   localparam int STEP_COLUMN_WRITE = 8;

   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic        first_column;
      logic [15:0] frame_number;
      logic [3:0]  thermal_nibble;
      logic [3:0]  shot_nibble;
      logic [15:0] column_id;
      logic [31:0] column_status;
      logic [63:0] column_timestamp;
      logic [63:0] packet_time;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [12:0] index_start;
      logic [12:0] index_end;
      logic [63:0] time_value;
      logic [31:0] status_value;
      logic [15:0] frame_value;
      logic [7:0]  frame_flags;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [NUM_STEPS-1:0]   steps;
      logic [15:0]            frame_number;
      logic [7:0]             frame_flags;
      logic [15:0]            old_frame;
      logic [7:0]             old_flags;
      logic [INDEX_WIDTH-1:0] tail_column_start;
      logic [INDEX_WIDTH-1:0] column_limit;
      logic [INDEX_WIDTH-1:0] tail_slot_start;
      logic [INDEX_WIDTH-1:0] slot_limit;
      logic [INDEX_WIDTH-1:0] slot_fill_start;
      logic [INDEX_WIDTH-1:0] slot_index;
      logic [INDEX_WIDTH-1:0] column_fill_start;
      logic [INDEX_WIDTH-1:0] column_index;
      logic [63:0]            packet_time;
      logic [63:0]            column_timestamp;
      logic [31:0]            column_status;
   } job_type;

endpackage

`default_nettype wire

// ----- hdl/lcfb_front.sv -----
// ----------------------------------------------------------------------------
// lcfb_front
// Holds configuration and frame tracking state, classifies each request and
// builds the job that lists the results it causes.
// ----------------------------------------------------------------------------
`default_nettype none

module lcfb_front #(
   parameter int MAX_COLUMNS = lcfb_pkg::MAX_COLUMNS_DEFAULT
) (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    csr_write_enable,
   input  wire  [lcfb_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire  [lcfb_pkg::CSR_DATA_WIDTH-1:0]    csr_write_data,
   input  wire                                    accept,
   input  lcfb_pkg::req_type                      req_data,
   output logic                                   job_push,
   output lcfb_pkg::job_type                      job
);

   localparam logic [lcfb_pkg::INDEX_WIDTH-1:0] MAX_WIDTH =
      lcfb_pkg::INDEX_WIDTH'(MAX_COLUMNS);
   localparam int PAD = lcfb_pkg::MID_WIDTH - lcfb_pkg::INDEX_WIDTH;

   logic [lcfb_pkg::INDEX_WIDTH-1:0] cfg_width_ff;
   logic [lcfb_pkg::LOG2_WIDTH-1:0]  cfg_log2_ff;

   logic [15:0]                      current_frame_ff, current_frame_in;
   logic [7:0]                       frame_status_ff, frame_status_in;
   logic                             frame_active_ff;
   logic                             dropping_ff, dropping_in;
   logic [lcfb_pkg::INDEX_WIDTH-1:0] next_column_ff, next_column_in;
   logic [lcfb_pkg::INDEX_WIDTH-1:0] next_slot_ff, next_slot_in;

   logic [lcfb_pkg::INDEX_WIDTH-1:0] width;
   logic [lcfb_pkg::LOG2_WIDTH-1:0]  lg;
   logic [lcfb_pkg::INDEX_WIDTH-1:0] slots;
   logic [15:0]                      frame_plus;
   logic [7:0]                       flags;
   logic                             reorder;
   logic                             new_frame;
   logic                             start;
   logic [lcfb_pkg::INDEX_WIDTH-1:0] column_base;
   logic [lcfb_pkg::INDEX_WIDTH-1:0] slot_base;
   logic [lcfb_pkg::MID_WIDTH-1:0]   slot_wide;
   logic [lcfb_pkg::INDEX_WIDTH-1:0] slot;
   logic [lcfb_pkg::INDEX_WIDTH-1:0] mid;
   logic                             slot_ok;
   logic                             slot_ahead;
   logic                             column_ok;
   logic                             column_ahead;
   logic [lcfb_pkg::NUM_STEPS-1:0]   steps;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff <= lcfb_pkg::COLUMNS_PER_FRAME_RESET;
         cfg_log2_ff  <= lcfb_pkg::LOG2_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            lcfb_pkg::CSR_COLUMNS_PER_FRAME: begin
               cfg_width_ff <= csr_write_data[lcfb_pkg::INDEX_WIDTH-1:0];
            end
            lcfb_pkg::CSR_COLUMNS_PER_PACKET_LOG2: begin
               cfg_log2_ff <= csr_write_data[lcfb_pkg::LOG2_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      width = (cfg_width_ff > MAX_WIDTH) ? MAX_WIDTH : cfg_width_ff;
      lg    = (cfg_log2_ff == lcfb_pkg::LOG2_ILLEGAL) ? lcfb_pkg::LOG2_MAX : cfg_log2_ff;
      slots = width >> lg;

      frame_plus = req_data.frame_number + 16'd1;
      flags      = {req_data.shot_nibble, req_data.thermal_nibble};
      reorder    = frame_active_ff && req_data.first_column &&
                   (current_frame_ff == frame_plus);
      new_frame  = frame_active_ff && req_data.first_column && !reorder &&
                   (current_frame_ff != req_data.frame_number);
      start      = !frame_active_ff || new_frame;

      if (!frame_active_ff) begin
         dropping_in = 1'b0;
      end else if (req_data.first_column) begin
         dropping_in = reorder;
      end else begin
         dropping_in = dropping_ff;
      end

      column_base = start ? '0 : next_column_ff;
      slot_base   = start ? '0 : next_slot_ff;

      slot_wide  = req_data.column_id >> lg;
      slot       = slot_wide[lcfb_pkg::INDEX_WIDTH-1:0];
      slot_ok    = req_data.first_column && !dropping_in &&
                   (slot_wide < {{PAD{1'b0}}, slots});
      slot_ahead = slot >= slot_base;

      mid          = req_data.column_id[lcfb_pkg::INDEX_WIDTH-1:0];
      column_ok    = !dropping_in && req_data.column_status[0] &&
                     (req_data.column_id < {{PAD{1'b0}}, width});
      column_ahead = mid >= column_base;

      steps                              = '0;
      steps[lcfb_pkg::STEP_DROP]         = reorder;
      steps[lcfb_pkg::STEP_TAIL_COLUMNS] = new_frame && (next_column_ff < width);
      steps[lcfb_pkg::STEP_TAIL_SLOTS]   = new_frame && (next_slot_ff < slots);
      steps[lcfb_pkg::STEP_COMPLETE]     = new_frame;
      steps[lcfb_pkg::STEP_START]        = start;
      steps[lcfb_pkg::STEP_ZERO_SLOTS]   = slot_ok && slot_ahead && (slot_base < slot);
      steps[lcfb_pkg::STEP_SLOT_WRITE]   = slot_ok;
      steps[lcfb_pkg::STEP_ZERO_COLUMNS] = column_ok && column_ahead && (column_base < mid);
      steps[lcfb_pkg::STEP_COLUMN_WRITE] = column_ok;

      next_slot_in     = (slot_ok && slot_ahead) ? slot + 1'b1 : slot_base;
      next_column_in   = (column_ok && column_ahead) ? mid + 1'b1 : column_base;
      current_frame_in = start ? req_data.frame_number : current_frame_ff;
      frame_status_in  = start ? flags : frame_status_ff;

      job.steps             = steps;
      job.frame_number      = req_data.frame_number;
      job.frame_flags       = flags;
      job.old_frame         = current_frame_ff;
      job.old_flags         = frame_status_ff;
      job.tail_column_start = next_column_ff;
      job.column_limit      = width;
      job.tail_slot_start   = next_slot_ff;
      job.slot_limit        = slots;
      job.slot_fill_start   = slot_base;
      job.slot_index        = slot;
      job.column_fill_start = column_base;
      job.column_index      = mid;
      job.packet_time       = req_data.packet_time;
      job.column_timestamp  = req_data.column_timestamp;
      job.column_status     = req_data.column_status;

      job_push = accept && (|steps);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         current_frame_ff <= '0;
         frame_status_ff  <= '0;
         frame_active_ff  <= 1'b0;
         dropping_ff      <= 1'b0;
         next_column_ff   <= '0;
         next_slot_ff     <= '0;
      end else if (accept) begin
         current_frame_ff <= current_frame_in;
         frame_status_ff  <= frame_status_in;
         frame_active_ff  <= 1'b1;
         dropping_ff      <= dropping_in;
         next_column_ff   <= next_column_in;
         next_slot_ff     <= next_slot_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/lcfb_queue.sv -----
// ----------------------------------------------------------------------------
// lcfb_queue
// Short job queue between the classifier and the result sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module lcfb_queue (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push,
   input  lcfb_pkg::job_type   push_data,
   input  wire                 pop,
   output lcfb_pkg::job_type   pop_data,
   output logic                full,
   output logic                empty
);

   localparam int DEPTH       = lcfb_pkg::QUEUE_DEPTH;
   localparam int PTR_WIDTH   = $clog2(DEPTH);
   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);
   localparam logic [PTR_WIDTH-1:0]   LAST_PTR  = PTR_WIDTH'(DEPTH - 1);
   localparam logic [COUNT_WIDTH-1:0] FULL_COUNT = COUNT_WIDTH'(DEPTH);

   lcfb_pkg::job_type       entries_ff [DEPTH];
   logic [PTR_WIDTH-1:0]    write_ptr_ff, write_ptr_in;
   logic [PTR_WIDTH-1:0]    read_ptr_ff, read_ptr_in;
   logic [COUNT_WIDTH-1:0]  count_ff, count_in;
   logic                    do_push;
   logic                    do_pop;

   always_comb begin
      full     = count_ff == FULL_COUNT;
      empty    = count_ff == '0;
      do_push  = push && !full;
      do_pop   = pop && !empty;
      pop_data = entries_ff[read_ptr_ff];

      write_ptr_in = write_ptr_ff;
      if (do_push) begin
         write_ptr_in = (write_ptr_ff == LAST_PTR) ? '0 : write_ptr_ff + 1'b1;
      end
      read_ptr_in = read_ptr_ff;
      if (do_pop) begin
         read_ptr_in = (read_ptr_ff == LAST_PTR) ? '0 : read_ptr_ff + 1'b1;
      end
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[write_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_ptr_ff <= '0;
         read_ptr_ff  <= '0;
         count_ff     <= '0;
      end else begin
         write_ptr_ff <= write_ptr_in;
         read_ptr_ff  <= read_ptr_in;
         count_ff     <= count_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/lcfb_back.sv -----
// ----------------------------------------------------------------------------
// lcfb_back
// Result sequencer: walks the pending steps of one job in step order and
// presents one result per cycle through the output register unless held.
// ----------------------------------------------------------------------------
`default_nettype none

module lcfb_back (
   input  wire                 clock,
   input  wire                 reset,
   input  lcfb_pkg::job_type   job,
   input  wire                 job_empty,
   output logic                job_pop,
   input  wire                 rsp_pop,
   output logic                rsp_empty,
   output lcfb_pkg::rsp_type   rsp_data
);

   logic [lcfb_pkg::NUM_STEPS-1:0] steps_ff, steps_in;
   lcfb_pkg::job_type              job_ff;
   logic                           out_valid_ff, out_valid_in;
   lcfb_pkg::rsp_type              out_data_ff;

   logic                           busy;
   logic                           emit;
   logic [lcfb_pkg::NUM_STEPS-1:0] low;
   logic [lcfb_pkg::NUM_STEPS-1:0] remaining;
   lcfb_pkg::rsp_type              result;

   always_comb begin
      busy      = |steps_ff;
      emit      = busy && (!out_valid_ff || rsp_pop);
      low       = steps_ff & (~steps_ff + 1'b1);
      remaining = steps_ff & ~low;
      job_pop   = !job_empty && (!busy || (emit && (remaining == '0)));

      if (job_pop) begin
         steps_in = job.steps;
      end else if (emit) begin
         steps_in = remaining;
      end else begin
         steps_in = steps_ff;
      end

      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end

      result      = '0;
      result.last = remaining == '0;
      if (low[lcfb_pkg::STEP_DROP]) begin
         result.kind        = lcfb_pkg::KIND_DROPPED;
         result.frame_value = job_ff.frame_number;
      end else if (low[lcfb_pkg::STEP_TAIL_COLUMNS]) begin
         result.kind        = lcfb_pkg::KIND_ZERO_COLUMNS;
         result.index_start = job_ff.tail_column_start;
         result.index_end   = job_ff.column_limit;
      end else if (low[lcfb_pkg::STEP_TAIL_SLOTS]) begin
         result.kind        = lcfb_pkg::KIND_ZERO_SLOTS;
         result.index_start = job_ff.tail_slot_start;
         result.index_end   = job_ff.slot_limit;
      end else if (low[lcfb_pkg::STEP_COMPLETE]) begin
         result.kind        = lcfb_pkg::KIND_FRAME_DONE;
         result.frame_value = job_ff.old_frame;
         result.frame_flags = job_ff.old_flags;
      end else if (low[lcfb_pkg::STEP_START]) begin
         result.kind        = lcfb_pkg::KIND_FRAME_START;
         result.frame_value = job_ff.frame_number;
         result.frame_flags = job_ff.frame_flags;
      end else if (low[lcfb_pkg::STEP_ZERO_SLOTS]) begin
         result.kind        = lcfb_pkg::KIND_ZERO_SLOTS;
         result.index_start = job_ff.slot_fill_start;
         result.index_end   = job_ff.slot_index;
      end else if (low[lcfb_pkg::STEP_SLOT_WRITE]) begin
         result.kind        = lcfb_pkg::KIND_PACKET_TIME;
         result.index_start = job_ff.slot_index;
         result.time_value  = job_ff.packet_time;
      end else if (low[lcfb_pkg::STEP_ZERO_COLUMNS]) begin
         result.kind        = lcfb_pkg::KIND_ZERO_COLUMNS;
         result.index_start = job_ff.column_fill_start;
         result.index_end   = job_ff.column_index;
      end else begin
         result.kind         = lcfb_pkg::KIND_COLUMN_WRITE;
         result.index_start  = job_ff.column_index;
         result.time_value   = job_ff.column_timestamp;
         result.status_value = job_ff.column_status;
      end

      rsp_empty = !out_valid_ff;
      rsp_data  = out_data_ff;
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         job_ff <= job;
      end
      if (emit) begin
         out_data_ff <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         steps_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         steps_ff     <= steps_in;
         out_valid_ff <= out_valid_in;
      end
   end

`ifndef ASSERT_OFF
   a_loaded_job_has_work: assert property (@(posedge clock) disable iff (reset)
      job_pop |=> (steps_ff != '0))
      else $error("sequencer loaded a job with no pending steps");

   a_drop_stands_alone: assert property (@(posedge clock) disable iff (reset)
      steps_ff[lcfb_pkg::STEP_DROP] |-> $onehot(steps_ff))
      else $error("drop step shares a job with other steps");

   a_result_budget: assert property (@(posedge clock) disable iff (reset)
      $countones(steps_ff) <= 8)
      else $error("job holds more than eight results");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_pop) |-> !emit)
      else $error("output register overwritten before it was taken");
`endif

endmodule

`default_nettype wire

// ----- hdl/lidar_column_frame_batcher_core.sv -----
// ----------------------------------------------------------------------------
// lidar_column_frame_batcher_core
// Gathers lidar column headers into frames and issues column, packet time,
// zero-fill, frame start, frame complete and drop results.
// ----------------------------------------------------------------------------
// A request is taken in any cycle in which req_full is low: the classifier
// updates the frame state in the cycle of acceptance and files a job in a
// four-entry queue. The sequencer emits one result per cycle from the head
// job while the result port is not held back; a request causes zero to
// eight results, and one that causes no result files no job and costs the
// sequencer nothing. A first result passes the queue entry, the job register
// and the output register before it reaches the result port. Sustained
// throughput is set by the sequencer's one result per cycle.
`default_nettype none

module lidar_column_frame_batcher_core #(
   parameter int MAX_COLUMNS = lcfb_pkg::MAX_COLUMNS_DEFAULT
) (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    csr_write_enable,
   input  wire  [lcfb_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire  [lcfb_pkg::CSR_DATA_WIDTH-1:0]    csr_write_data,
   input  wire                                    req_push,
   output logic                                   req_full,
   input  lcfb_pkg::req_type                      req_data,
   output logic                                   rsp_empty,
   input  wire                                    rsp_pop,
   output lcfb_pkg::rsp_type                      rsp_data
);

   logic                queue_full;
   logic                queue_empty;
   logic                accept;
   logic                job_push;
   logic                job_pop;
   lcfb_pkg::job_type   front_job;
   lcfb_pkg::job_type   head_job;

   assign req_full = queue_full;
   assign accept   = req_push && !queue_full;

   lcfb_front #(
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .accept           (accept),
      .req_data         (req_data),
      .job_push         (job_push),
      .job              (front_job)
   );

   lcfb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (front_job),
      .pop       (job_pop),
      .pop_data  (head_job),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   lcfb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job       (head_job),
      .job_empty (queue_empty),
      .job_pop   (job_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
